// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the core.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ERTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs through reset.
`define ERTP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/ertp_pkg.sv -----
// Shared constants, request codes and the job type of the echo range core.
// No dependencies.
`timescale 1ns / 1ps

package ertp_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int CAPTURE_W   = 16;
    localparam int OVF_W       = 16;
    localparam int STAMP_W     = 32;
    // width*64 mod 2^32 depends only on the low 26 bits of the width
    localparam int WIDTH_KEEP  = STAMP_W - 6;
    localparam int DIST_W      = 23;
    localparam int TONE_W      = 8;
    localparam int PERIOD_W    = 8;
    localparam int DUTY_W      = 6;
    localparam int ADC_W       = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // (w*64)/928 == (2*w)/29; divide by 29 as multiply by ceil(2^32/29)
    localparam int          DIV29_SHIFT = 32;
    localparam logic [27:0] DIV29_RECIP = 28'd148102321;

    // Q16 mapping: 0.086 and 29.57
    localparam int          TONE_FRAC   = 16;
    localparam logic [12:0] TONE_GAIN   = 13'd5636;
    localparam logic [20:0] TONE_OFFSET = 21'd1937900;

    // divide by 100 as multiply by ceil(2^21/100)
    localparam int          DIV100_SHIFT = 21;
    localparam logic [14:0] DIV100_RECIP = 15'd20972;

    localparam logic [1:0] REQ_CAPTURE  = 2'd0;
    localparam logic [1:0] REQ_OVERFLOW = 2'd1;
    localparam logic [1:0] REQ_ADC      = 2'd2;

    typedef struct packed {
        logic [WIDTH_KEEP-1:0] width;
        logic                  button;
        logic [DUTY_W-1:0]     duty;
    } t_job;

endpackage

// ----- rtl/core/echo_range_to_tone_period_core.sv -----
// Top level of the echo range to tone period core.
// Instantiates ertp_front, ertp_queue and ertp_back; depends on ertp_pkg.
`timescale 1ns / 1ps

// Usage:
//  Input channel (i_valid / o_stall): one item per event. i_req_type picks a
//  capture edge, a timer overflow tick or an ADC sample; code 3 is dropped.
//  Output channel (o_valid / i_stall): one item per falling capture edge,
//  carrying distance, tone value, tone period and compare value.
//  Throughput: one input item per cycle while o_stall is low. The front part
//  updates timestamp and duty state in the accept cycle and queues a job per
//  falling edge. Path: an accepted falling edge is written into the job queue,
//  then, while the receiver does not stall, passes three multiply stages:
//  divide by 29, Q16 tone mapping, period times duty, then divide by 100 into
//  the output register.
//  Stall: while i_stall holds over a valid result, the result item holds and
//  the back pipeline freezes. The front keeps taking items into a four-entry
//  job queue; o_stall rises only once that queue is full.
//  Reset (i_rst_n low, synchronous): clear timestamp, overflow count, edge
//  phase (next edge is rising), duty, period and all valid flags.
module echo_range_to_tone_period_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_req_type,
    input  logic [ertp_pkg::CAPTURE_W-1:0] i_capture_count,
    input  logic                           i_button_level,
    input  logic [ertp_pkg::ADC_W-1:0]     i_adc_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ertp_pkg::DIST_W-1:0]    o_distance_cm,
    output logic [ertp_pkg::TONE_W-1:0]    o_tone_value,
    output logic [ertp_pkg::PERIOD_W-1:0]  o_tone_period,
    output logic [ertp_pkg::PERIOD_W-1:0]  o_tone_compare
);
    import ertp_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    t_job job_in;
    t_job job_out;

    // accept whenever the queue has room; only falling edges take a slot
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    ertp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_req_type      (i_req_type),
        .i_capture_count (i_capture_count),
        .i_button_level  (i_button_level),
        .i_adc_sample    (i_adc_sample),
        .o_push          (push),
        .o_job           (job_in)
    );

    ertp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (job_out)
    );

    ertp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_distance_cm  (o_distance_cm),
        .o_tone_value   (o_tone_value),
        .o_tone_period  (o_tone_period),
        .o_tone_compare (o_tone_compare)
    );

endmodule

// ----- rtl/core/ertp_front.sv -----
// Front part: takes every event, keeps timestamp and duty state, and
// emits one job per falling edge. Depends on ertp_pkg.
`timescale 1ns / 1ps

module ertp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    input  logic [ertp_pkg::CAPTURE_W-1:0] i_capture_count,
    input  logic                        i_button_level,
    input  logic [ertp_pkg::ADC_W-1:0]  i_adc_sample,
    output logic                        o_push,
    output ertp_pkg::t_job              o_job
);
    import ertp_pkg::*;

    localparam logic [ADC_W-1:0] ADC_BOUNDS [11] = '{
        10'd50, 10'd141, 10'd232, 10'd323, 10'd414, 10'd505,
        10'd596, 10'd687, 10'd778, 10'd896, 10'd970
    };
    localparam logic [CAPTURE_W-1:0] CAP_MASK = (TIMER_BITS >= CAPTURE_W) ?
        {CAPTURE_W{1'b1}} : CAPTURE_W'((64'd1 << TIMER_BITS) - 64'd1);

    logic [OVF_W-1:0]   r_ovf,   n_ovf;
    logic [STAMP_W-1:0] r_last,  n_last;
    logic               r_fall,  n_fall;
    logic [DUTY_W-1:0]  r_duty,  n_duty;

    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] width;
    logic [DUTY_W-1:0]  ladder_duty;
    logic               ladder_hit;

    always_comb begin
        stamp = STAMP_W'(64'(i_capture_count & CAP_MASK) + (64'(r_ovf) << TIMER_BITS));
        width = stamp - r_last;
    end

    always_comb begin
        ladder_duty = '0;
        ladder_hit  = 1'b0;
        for (int i = 0; i < 10; i++) begin
            if (i_adc_sample >= ADC_BOUNDS[i] && i_adc_sample < ADC_BOUNDS[i+1]) begin
                ladder_duty = DUTY_W'(5 * (i + 1));
                ladder_hit  = 1'b1;
            end
        end
    end

    always_comb begin
        n_ovf  = r_ovf;
        n_last = r_last;
        n_fall = r_fall;
        n_duty = r_duty;
        o_push = 1'b0;
        if (i_accept) begin
            unique case (i_req_type)
                REQ_OVERFLOW: n_ovf = r_ovf + OVF_W'(1);
                REQ_ADC: begin
                    if (ladder_hit) n_duty = ladder_duty;
                end
                REQ_CAPTURE: begin
                    n_last = stamp;
                    n_fall = !r_fall;
                    o_push = r_fall;
                end
                default: ;
            endcase
        end
    end

    assign o_job.width  = width[WIDTH_KEEP-1:0];
    assign o_job.button = i_button_level;
    assign o_job.duty   = r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf  <= '0;
            r_last <= '0;
            r_fall <= 1'b0;
            r_duty <= '0;
        end else begin
            r_ovf  <= n_ovf;
            r_last <= n_last;
            r_fall <= n_fall;
            r_duty <= n_duty;
        end
    end

endmodule

// ----- rtl/core/ertp_queue.sv -----
// Short job queue between front and back parts.
// Depends on ertp_pkg.
`timescale 1ns / 1ps

module ertp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ertp_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output ertp_pkg::t_job o_job
);
    import ertp_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

// ----- rtl/core/ertp_back.sv -----
// Back part: four-stage pipeline from echo width to distance, tone value,
// period and compare. Holds period state. Depends on ertp_pkg.
`timescale 1ns / 1ps

module ertp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  ertp_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ertp_pkg::DIST_W-1:0]  o_distance_cm,
    output logic [ertp_pkg::TONE_W-1:0]  o_tone_value,
    output logic [ertp_pkg::PERIOD_W-1:0] o_tone_period,
    output logic [ertp_pkg::PERIOD_W-1:0] o_tone_compare
);
    import ertp_pkg::*;

    localparam int Q_W    = WIDTH_KEEP + 1 + 28;
    localparam int TSUM_W = DIST_W + 14;
    localparam int CPR_W  = PERIOD_W + DUTY_W;
    localparam int CMUL_W = CPR_W + 15;

    function automatic logic [PERIOD_W-1:0] step_period(
        input logic [TONE_W-1:0] v, input logic [PERIOD_W-1:0] old);
        logic [PERIOD_W-1:0] p;
        priority if (v >= 8'd60) p = 8'd120;
        else if (v >= 8'd53) p = 8'd106;
        else if (v >= 8'd47) p = 8'd94;
        else if (v >= 8'd45) p = 8'd90;
        else if (v >= 8'd40) p = 8'd80;
        else if (v >= 8'd36) p = 8'd72;
        else if (v >= 8'd32) p = 8'd64;
        else if (v >= 8'd28) p = 8'd60;
        else p = old;
        return p;
    endfunction

    logic en;
    logic r_v1, r_v2, r_v3, r_vo;
    logic [PERIOD_W-1:0] r_period_reg, n_period_reg;

    logic [DIST_W-1:0]   r_dist1, r_dist2, r_dist3, r_dist_o;
    logic                r_btn1, r_btn2;
    logic [DUTY_W-1:0]   r_duty1, r_duty2;
    logic [TONE_W-1:0]   r_tone2, r_tone3, r_tone_o;
    logic [PERIOD_W-1:0] r_per3, r_per_o;
    logic [CPR_W-1:0]    r_cprod3;
    logic [PERIOD_W-1:0] r_cmp_o;

    logic [Q_W-1:0]      quot_prod;
    logic [TSUM_W-1:0]   tone_sum;
    logic [TSUM_W-TONE_FRAC-1:0] tone_raw;
    logic [TONE_W-1:0]   tone;
    logic [PERIOD_W-1:0] period;
    logic [CMUL_W-1:0]   cmp_mul;

    assign en    = !r_vo || !i_stall;
    assign o_pop = en && i_job_valid;

    always_comb begin
        quot_prod = Q_W'({i_job.width, 1'b0}) * Q_W'(DIV29_RECIP);
        tone_sum  = TSUM_W'(r_dist1) * TSUM_W'(TONE_GAIN) + TSUM_W'(TONE_OFFSET);
        tone_raw  = tone_sum[TSUM_W-1:TONE_FRAC];
        tone      = (|tone_raw[TSUM_W-TONE_FRAC-1:TONE_W]) ? {TONE_W{1'b1}}
                                                           : tone_raw[TONE_W-1:0];
        period    = r_btn2 ? step_period(r_tone2, r_period_reg)
                           : {r_tone2[TONE_W-2:0], 1'b0};
        n_period_reg = (en && r_v2) ? period : r_period_reg;
        cmp_mul   = CMUL_W'(r_cprod3) * CMUL_W'(DIV100_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
            r_period_reg <= '0;
        end else begin
            if (en) begin
                r_v1 <= i_job_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_vo <= r_v3;
            end
            r_period_reg <= n_period_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist1  <= quot_prod[DIV29_SHIFT +: DIST_W];
            r_btn1   <= i_job.button;
            r_duty1  <= i_job.duty;
            r_dist2  <= r_dist1;
            r_btn2   <= r_btn1;
            r_duty2  <= r_duty1;
            r_tone2  <= tone;
            r_dist3  <= r_dist2;
            r_tone3  <= r_tone2;
            r_per3   <= period;
            r_cprod3 <= CPR_W'(period) * CPR_W'(r_duty2);
            r_dist_o <= r_dist3;
            r_tone_o <= r_tone3;
            r_per_o  <= r_per3;
            r_cmp_o  <= cmp_mul[DIV100_SHIFT +: PERIOD_W];
        end
    end

    assign o_valid        = r_vo;
    assign o_distance_cm  = r_dist_o;
    assign o_tone_value   = r_tone_o;
    assign o_tone_period  = r_per_o;
    assign o_tone_compare = r_cmp_o;

endmodule

// ----- rtl/core/ertp_checker.sv -----
// Port-level checker for the echo range core, bound to the top level.
// Depends on ertp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ertp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [ertp_pkg::DIST_W-1:0]    o_distance_cm,
    input  logic [ertp_pkg::TONE_W-1:0]    o_tone_value,
    input  logic [ertp_pkg::PERIOD_W-1:0]  o_tone_period,
    input  logic [ertp_pkg::PERIOD_W-1:0]  o_tone_compare
);
    import ertp_pkg::*;

    localparam int                RES_W     = DIST_W + TONE_W + 2 * PERIOD_W;
    // the 29.57 offset truncates to 29 at zero range
    localparam logic [TONE_W-1:0] ZERO_TONE = 8'd29;

    logic [RES_W-1:0]    result_bits;
    logic [PERIOD_W-1:0] half_period;
    logic                zero_range;

    assign result_bits = {o_distance_cm, o_tone_value, o_tone_period, o_tone_compare};
    assign half_period = o_tone_period >> 1;
    assign zero_range  = o_valid && (o_distance_cm == '0);

    `ERTP_ASSERT_RST(a_reset_clears, (!i_rst_n |=> !o_valid), "result valid after reset")
    `ERTP_ASSERT(a_hold_valid, (o_valid && i_stall |=> o_valid), "stalled result dropped")
    `ERTP_ASSERT(a_hold_data, (o_valid && i_stall |=> $stable(result_bits)), "result not held")
    `ERTP_ASSERT(a_cmp_bound, (o_valid |-> o_tone_compare <= half_period), "compare too large")
    `ERTP_ASSERT(a_zero_range, (zero_range |-> o_tone_value == ZERO_TONE), "zero range tone")

endmodule

bind echo_range_to_tone_period_core ertp_checker u_ertp_checker (.*);
